// ===== hw/rtl/tlwg_pkg.sv =====
package tlwg_pkg;

  // word widths of the ports
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CORNER_W  = 3;
  localparam int NODE_W    = 16;
  localparam int WEIGHT_W  = 17;
  localparam int GRAD_W    = 18;

  localparam int NUM_AXES    = 3;
  localparam int NUM_CORNERS = 8;

  // register indexes of the write port
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd5;

  // reset value of inverse spacing: 1.0 in q16.16
  localparam logic [DATA_W-1:0] INV_RESET = 32'h0001_0000;

  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NUM_CORNERS - 1);

endpackage

// ===== hw/rtl/tlwg_axis_map.sv =====
module tlwg_axis_map #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [tlwg_pkg::DATA_W-1:0]  pos_i,
  input  logic [tlwg_pkg::DATA_W-1:0]  origin_i,
  input  logic [tlwg_pkg::DATA_W-1:0]  inv_i,
  output logic                         valid_o,
  output logic [INDEX_BITS-1:0]        node_lo_o,
  output logic [INDEX_BITS-1:0]        node_hi_o,
  output logic [FRAC_BITS-1:0]         frac_o
);

  localparam int DW   = tlwg_pkg::DATA_W + 1;
  localparam int HW   = tlwg_pkg::DATA_W / 2;
  localparam int PW   = tlwg_pkg::DATA_W + HW;
  localparam int PRW  = 2 * tlwg_pkg::DATA_W;
  localparam int QW   = PRW - FRAC_BITS;
  localparam int CW   = QW + 1;
  localparam int BW   = CW - FRAC_BITS;
  localparam int SW   = (BW + 1 > INDEX_BITS + 1) ? BW + 1 : INDEX_BITS + 1;
  localparam logic signed [SW-1:0] IDX_MAX = SW'((64'sd1 <<< (INDEX_BITS - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] IDX_MIN = ~IDX_MAX;

  logic [5:0] vld_q;

  logic [DW-1:0] diff_d, diff_q;
  logic [DW-1:0] mag_full;
  logic [tlwg_pkg::DATA_W-1:0] mag_d, mag_q;
  logic neg2_q, neg3_q, neg4_q;
  logic [PW-1:0]  plo_d, plo_q, phi_d, phi_q;
  logic [PRW-1:0] prod_d, prod_q;
  logic [CW-1:0]  qx;
  logic           rem_nz;
  logic [CW-1:0]  scaled_d, scaled_q;
  logic signed [SW-1:0] base_s, base1_s;
  logic [INDEX_BITS-1:0] node_lo_d, node_hi_d;
  logic [INDEX_BITS-1:0] node_lo_q, node_hi_q;
  logic [FRAC_BITS-1:0]  frac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // difference, exact in 33 bits
  assign diff_d = {pos_i[tlwg_pkg::DATA_W-1], pos_i} - {origin_i[tlwg_pkg::DATA_W-1], origin_i};

  // magnitude
  assign mag_full = diff_q[DW-1] ? (DW'(0) - diff_q) : diff_q;
  assign mag_d    = mag_full[tlwg_pkg::DATA_W-1:0];

  // two 32x16 partial products
  assign plo_d = PW'(mag_q) * PW'(inv_i[HW-1:0]);
  assign phi_d = PW'(mag_q) * PW'(inv_i[tlwg_pkg::DATA_W-1:HW]);

  assign prod_d = PRW'(plo_q) + {phi_q, {HW{1'b0}}};

  // floor toward minus infinity: -(q+1) is ~q
  assign qx       = {1'b0, prod_q[PRW-1:FRAC_BITS]};
  assign rem_nz   = |prod_q[FRAC_BITS-1:0];
  assign scaled_d = !neg4_q ? qx : (rem_nz ? ~qx : (CW'(0) - qx));

  // saturate base and base + 1
  assign base_s  = {{(SW-BW){scaled_q[CW-1]}}, scaled_q[CW-1:FRAC_BITS]};
  assign base1_s = base_s + SW'(1);

  always_comb begin
    if (base_s > IDX_MAX) begin
      node_lo_d = IDX_MAX[INDEX_BITS-1:0];
    end else if (base_s < IDX_MIN) begin
      node_lo_d = IDX_MIN[INDEX_BITS-1:0];
    end else begin
      node_lo_d = base_s[INDEX_BITS-1:0];
    end
    if (base1_s > IDX_MAX) begin
      node_hi_d = IDX_MAX[INDEX_BITS-1:0];
    end else if (base1_s < IDX_MIN) begin
      node_hi_d = IDX_MIN[INDEX_BITS-1:0];
    end else begin
      node_hi_d = base1_s[INDEX_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    mag_q     <= mag_d;
    neg2_q    <= diff_q[DW-1];
    plo_q     <= plo_d;
    phi_q     <= phi_d;
    neg3_q    <= neg2_q;
    prod_q    <= prod_d;
    neg4_q    <= neg3_q;
    scaled_q  <= scaled_d;
    node_lo_q <= node_lo_d;
    node_hi_q <= node_hi_d;
    frac_q    <= scaled_q[FRAC_BITS-1:0];
  end

  assign valid_o   = vld_q[5];
  assign node_lo_o = node_lo_q;
  assign node_hi_o = node_hi_q;
  assign frac_o    = frac_q;

endmodule

// ===== hw/rtl/tlwg_corner_seq.sv =====
module tlwg_corner_seq #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic [INDEX_BITS-1:0]            node_lo_i [tlwg_pkg::NUM_AXES],
  input  logic [INDEX_BITS-1:0]            node_hi_i [tlwg_pkg::NUM_AXES],
  input  logic [FRAC_BITS-1:0]             frac_i [tlwg_pkg::NUM_AXES],
  output logic                             valid_o,
  output logic [tlwg_pkg::CORNER_W-1:0]    corner_o,
  output logic                             last_o,
  output logic [tlwg_pkg::NODE_W-1:0]      node_o [tlwg_pkg::NUM_AXES],
  output logic [tlwg_pkg::WEIGHT_W-1:0]    weight_o,
  output logic [tlwg_pkg::GRAD_W-1:0]      grad_o [tlwg_pkg::NUM_AXES]
);

  localparam int WF  = FRAC_BITS + 1;
  localparam int MW  = 2 * WF;
  localparam int WW  = (WF > tlwg_pkg::WEIGHT_W) ? WF : tlwg_pkg::WEIGHT_W;
  localparam int GXW = (FRAC_BITS + 2 > tlwg_pkg::GRAD_W) ? FRAC_BITS + 2 : tlwg_pkg::GRAD_W;
  localparam int NW  = (INDEX_BITS + 1 > tlwg_pkg::NODE_W) ? INDEX_BITS + 1 : tlwg_pkg::NODE_W;
  localparam logic [WF-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // held item
  logic                  run_q;
  logic [tlwg_pkg::CORNER_W-1:0] cnt_q;
  logic [INDEX_BITS-1:0] lo_q [tlwg_pkg::NUM_AXES];
  logic [INDEX_BITS-1:0] hi_q [tlwg_pkg::NUM_AXES];
  logic [FRAC_BITS-1:0]  f_q  [tlwg_pkg::NUM_AXES];

  // stage 1: corner select
  logic                  c1_v_q;
  logic [tlwg_pkg::CORNER_W-1:0] c1_corner_q;
  logic [WF-1:0]         c1_w_d [tlwg_pkg::NUM_AXES];
  logic [WF-1:0]         c1_w_q [tlwg_pkg::NUM_AXES];
  logic [INDEX_BITS-1:0] c1_n_d [tlwg_pkg::NUM_AXES];
  logic [INDEX_BITS-1:0] c1_n_q [tlwg_pkg::NUM_AXES];

  // stage 2: pair products
  logic                  c2_v_q;
  logic [tlwg_pkg::CORNER_W-1:0] c2_corner_q;
  logic [MW-1:0]         pxy, pyz, pxz;
  logic [WF-1:0]         sxy_q, syz_q, sxz_q, c2_wz_q;
  logic [INDEX_BITS-1:0] c2_n_q [tlwg_pkg::NUM_AXES];

  // stage 3: weight and gradients
  logic [MW-1:0]  pw;
  logic [WW-1:0]  w_ext;
  logic [GXW-1:0] g_mag [tlwg_pkg::NUM_AXES];
  logic [GXW-1:0] g_val [tlwg_pkg::NUM_AXES];
  logic [NW-1:0]  n_ext [tlwg_pkg::NUM_AXES];
  logic           c3_v_q;
  logic [tlwg_pkg::CORNER_W-1:0] c3_corner_q;
  logic           c3_last_q;
  logic [tlwg_pkg::NODE_W-1:0]   c3_n_q [tlwg_pkg::NUM_AXES];
  logic [tlwg_pkg::WEIGHT_W-1:0] c3_w_q;
  logic [tlwg_pkg::GRAD_W-1:0]   c3_g_q [tlwg_pkg::NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      c1_v_q <= 1'b0;
      c2_v_q <= 1'b0;
      c3_v_q <= 1'b0;
    end else begin
      if (valid_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + tlwg_pkg::CORNER_W'(1);
        if (cnt_q == tlwg_pkg::LAST_CORNER) begin
          run_q <= 1'b0;
        end
      end
      c1_v_q <= run_q;
      c2_v_q <= c1_v_q;
      c3_v_q <= c2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      lo_q <= node_lo_i;
      hi_q <= node_hi_i;
      f_q  <= frac_i;
    end
  end

  // corner bit 2 is x, bit 0 is z
  always_comb begin
    for (int a = 0; a < tlwg_pkg::NUM_AXES; a++) begin
      c1_w_d[a] = cnt_q[2-a] ? {1'b0, f_q[a]} : (ONE - {1'b0, f_q[a]});
      c1_n_d[a] = cnt_q[2-a] ? hi_q[a] : lo_q[a];
    end
  end

  assign pxy = MW'(c1_w_q[0]) * MW'(c1_w_q[1]);
  assign pyz = MW'(c1_w_q[1]) * MW'(c1_w_q[2]);
  assign pxz = MW'(c1_w_q[0]) * MW'(c1_w_q[2]);

  assign pw    = MW'(sxy_q) * MW'(c2_wz_q);
  assign w_ext = WW'(pw[MW-2:FRAC_BITS]);

  always_comb begin
    g_mag[0] = GXW'(syz_q);
    g_mag[1] = GXW'(sxz_q);
    g_mag[2] = GXW'(sxy_q);
    for (int a = 0; a < tlwg_pkg::NUM_AXES; a++) begin
      g_val[a] = c2_corner_q[2-a] ? g_mag[a] : (GXW'(0) - g_mag[a]);
      n_ext[a] = {{(NW-INDEX_BITS){c2_n_q[a][INDEX_BITS-1]}}, c2_n_q[a]};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_corner_q <= cnt_q;
    c1_w_q      <= c1_w_d;
    c1_n_q      <= c1_n_d;
    c2_corner_q <= c1_corner_q;
    sxy_q       <= pxy[MW-2:FRAC_BITS];
    syz_q       <= pyz[MW-2:FRAC_BITS];
    sxz_q       <= pxz[MW-2:FRAC_BITS];
    c2_wz_q     <= c1_w_q[2];
    c2_n_q      <= c1_n_q;
    c3_corner_q <= c2_corner_q;
    c3_last_q   <= (c2_corner_q == tlwg_pkg::LAST_CORNER);
    c3_w_q      <= w_ext[tlwg_pkg::WEIGHT_W-1:0];
    for (int a = 0; a < tlwg_pkg::NUM_AXES; a++) begin
      c3_g_q[a] <= g_val[a][tlwg_pkg::GRAD_W-1:0];
      c3_n_q[a] <= n_ext[a][tlwg_pkg::NODE_W-1:0];
    end
  end

  assign valid_o  = c3_v_q;
  assign corner_o = c3_corner_q;
  assign last_o   = c3_last_q;
  assign node_o   = c3_n_q;
  assign weight_o = c3_w_q;
  assign grad_o   = c3_g_q;

endmodule

// ===== hw/rtl/trilinear_weights_and_gradients.sv =====
// output: the first result word follows the axis map and corner pipelines,
//   the remaining seven corners follow on consecutive cycles
// issue rate: one position per corner burst, set by the single result word per cycle;
//   after each accept busy is high until the gap count is zero; the pipeline keeps working
// reset: rst_ni low clears all valid bits and restores origin 0 and inverse spacing 1.0
// the receiver cannot stall: every strobed word is taken in its cycle
module trilinear_weights_and_gradients #(
  parameter int FRAC_BITS  = 16,
  parameter int INDEX_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  logic signed [tlwg_pkg::DATA_W-1:0] pos_x_i,
  input  logic signed [tlwg_pkg::DATA_W-1:0] pos_y_i,
  input  logic signed [tlwg_pkg::DATA_W-1:0] pos_z_i,
  // register write port
  input  logic                              cfg_we_i,
  input  logic [tlwg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tlwg_pkg::DATA_W-1:0]       cfg_wdata_i,
  // result side
  output logic                              result_valid_o,
  output logic [tlwg_pkg::CORNER_W-1:0]     corner_o,
  output logic signed [tlwg_pkg::NODE_W-1:0] node_x_o,
  output logic signed [tlwg_pkg::NODE_W-1:0] node_y_o,
  output logic signed [tlwg_pkg::NODE_W-1:0] node_z_o,
  output logic [tlwg_pkg::WEIGHT_W-1:0]     weight_o,
  output logic signed [tlwg_pkg::GRAD_W-1:0] grad_x_o,
  output logic signed [tlwg_pkg::GRAD_W-1:0] grad_y_o,
  output logic signed [tlwg_pkg::GRAD_W-1:0] grad_z_o,
  output logic                              last_o
);

  localparam int GAP_W = $clog2(tlwg_pkg::NUM_CORNERS);

  logic [tlwg_pkg::DATA_W-1:0] origin_q [tlwg_pkg::NUM_AXES];
  logic [tlwg_pkg::DATA_W-1:0] inv_q    [tlwg_pkg::NUM_AXES];
  logic [tlwg_pkg::DATA_W-1:0] pos      [tlwg_pkg::NUM_AXES];

  logic             accept;
  logic [GAP_W-1:0] gap_q;

  logic [tlwg_pkg::NUM_AXES-1:0] map_valid;
  logic [INDEX_BITS-1:0] node_lo [tlwg_pkg::NUM_AXES];
  logic [INDEX_BITS-1:0] node_hi [tlwg_pkg::NUM_AXES];
  logic [FRAC_BITS-1:0]  frac    [tlwg_pkg::NUM_AXES];

  logic [tlwg_pkg::NODE_W-1:0] node [tlwg_pkg::NUM_AXES];
  logic [tlwg_pkg::GRAD_W-1:0] grad [tlwg_pkg::NUM_AXES];

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < tlwg_pkg::NUM_AXES; a++) begin
        origin_q[a] <= '0;
        inv_q[a]    <= tlwg_pkg::INV_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlwg_pkg::REG_ORIGIN_X: origin_q[0] <= cfg_wdata_i;
        tlwg_pkg::REG_ORIGIN_Y: origin_q[1] <= cfg_wdata_i;
        tlwg_pkg::REG_ORIGIN_Z: origin_q[2] <= cfg_wdata_i;
        tlwg_pkg::REG_INV_X:    inv_q[0]    <= cfg_wdata_i;
        tlwg_pkg::REG_INV_Y:    inv_q[1]    <= cfg_wdata_i;
        tlwg_pkg::REG_INV_Z:    inv_q[2]    <= cfg_wdata_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // issue spacing: start is taken only at gap count zero; this keeps the corner sequencer fed
  // without overlap, since every path to it has the same depth
  assign accept = start && (gap_q == '0);
  assign busy   = (gap_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= '0;
    end else if (accept) begin
      gap_q <= GAP_W'(tlwg_pkg::NUM_CORNERS - 1);
    end else if (gap_q != '0) begin
      gap_q <= gap_q - GAP_W'(1);
    end
  end

  assign pos[0] = pos_x_i;
  assign pos[1] = pos_y_i;
  assign pos[2] = pos_z_i;

  // per-axis index mapping pipeline: difference, magnitude, partial products,
  // sum, floor, saturation
  for (genvar a = 0; a < tlwg_pkg::NUM_AXES; a++) begin : g_axis
    tlwg_axis_map #(
      .FRAC_BITS (FRAC_BITS),
      .INDEX_BITS(INDEX_BITS)
    ) u_map (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (accept),
      .pos_i    (pos[a]),
      .origin_i (origin_q[a]),
      .inv_i    (inv_q[a]),
      .valid_o  (map_valid[a]),
      .node_lo_o(node_lo[a]),
      .node_hi_o(node_hi[a]),
      .frac_o   (frac[a])
    );
  end

  // corner walk: eight words, z fastest, through a three-stage product pipeline
  tlwg_corner_seq #(
    .FRAC_BITS (FRAC_BITS),
    .INDEX_BITS(INDEX_BITS)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (map_valid[0]),
    .node_lo_i(node_lo),
    .node_hi_i(node_hi),
    .frac_i   (frac),
    .valid_o  (result_valid_o),
    .corner_o (corner_o),
    .last_o   (last_o),
    .node_o   (node),
    .weight_o (weight_o),
    .grad_o   (grad)
  );

  assign node_x_o = node[0];
  assign node_y_o = node[1];
  assign node_z_o = node[2];
  assign grad_x_o = grad[0];
  assign grad_y_o = grad[1];
  assign grad_z_o = grad[2];

  // the last flag marks corner seven only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> corner_o == tlwg_pkg::LAST_CORNER)
    else $error("last word not on the final corner");

  // corners of one position come on consecutive cycles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("gap inside a corner burst");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=>
      corner_o == tlwg_pkg::CORNER_W'($past(corner_o) + tlwg_pkg::CORNER_W'(1)))
    else $error("corner order broken");

  // the three axis pipelines stay in lock step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_valid[0] == map_valid[1] && map_valid[0] == map_valid[2])
    else $error("axis pipelines out of step");

  // an accepted position blocks the next start for the burst length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accept not followed by busy");

endmodule

// ===== sim/tlwg_checker.sv =====
module tlwg_checker import tlwg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic                     busy_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [DATA_W-1:0]        cfg_wdata_i,
  input  logic                     result_valid_i,
  input  logic [CORNER_W-1:0]      corner_i,
  input  logic signed [NODE_W-1:0] node_x_i,
  input  logic signed [NODE_W-1:0] node_y_i,
  input  logic signed [NODE_W-1:0] node_z_i,
  input  logic [WEIGHT_W-1:0]      weight_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  input  logic signed [GRAD_W-1:0] grad_z_i,
  input  logic                     last_i,
  output int                       fail_cnt_o,
  output int                       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC     = 16;
  localparam longint      NODE_MAX = (64'sd1 <<< (NODE_W - 1)) - 1;
  localparam longint      NODE_MIN = -(64'sd1 <<< (NODE_W - 1));
  localparam logic [63:0] ONE      = 64'd1 << FRAC;

  typedef struct packed {
    logic [CORNER_W-1:0]     corner;
    logic signed [NODE_W-1:0] node_x;
    logic signed [NODE_W-1:0] node_y;
    logic signed [NODE_W-1:0] node_z;
    logic [WEIGHT_W-1:0]     weight;
    logic signed [GRAD_W-1:0] grad_x;
    logic signed [GRAD_W-1:0] grad_y;
    logic signed [GRAD_W-1:0] grad_z;
    logic                    last;
  } corner_word_t;

  corner_word_t             expected_corners[$];
  corner_word_t             want;
  logic signed [DATA_W-1:0] origin [NUM_AXES];
  logic [DATA_W-1:0]        inv_spacing [NUM_AXES];
  int                       fail_cnt = 0;
  int                       pending  = 0;

  assign fail_cnt_o = fail_cnt;
  assign pending_o  = pending;

  // floor of (pos - origin) * inv, split into cell index and fraction
  function automatic void map_to_index(input logic signed [DATA_W-1:0] pos, org,
                                       input logic [DATA_W-1:0] inv,
                                       output logic signed [63:0] base,
                                       output logic [63:0] frac);
    logic signed [63:0] diff;
    logic signed [63:0] scaled;
    logic [63:0]        mag;
    logic [63:0]        prod;
    logic [63:0]        q;
    diff = longint'(pos) - longint'(org);
    mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
    prod = mag * {32'd0, inv};
    q    = prod >> FRAC;
    if (diff < 0 && prod[FRAC-1:0] != '0) q = q + 64'd1;
    scaled = (diff < 0) ? -$signed(q) : $signed(q);
    frac = 64'(scaled[FRAC-1:0]);
    base = scaled >>> FRAC;
  endfunction

  function automatic logic signed [NODE_W-1:0] clamp_node(input logic signed [63:0] v);
    if (v > NODE_MAX) return NODE_W'(NODE_MAX);
    if (v < NODE_MIN) return NODE_W'(NODE_MIN);
    return NODE_W'(v);
  endfunction

  function automatic void predict_corners(input logic signed [DATA_W-1:0] px, py, pz);
    logic signed [63:0] base [NUM_AXES];
    logic [63:0]        frac [NUM_AXES];
    logic [63:0]        wt [NUM_AXES];
    logic [63:0]        gx;
    logic [63:0]        gy;
    logic [63:0]        gz;
    logic [2:0]         ofs;
    corner_word_t       word;
    map_to_index(px, origin[0], inv_spacing[0], base[0], frac[0]);
    map_to_index(py, origin[1], inv_spacing[1], base[1], frac[1]);
    map_to_index(pz, origin[2], inv_spacing[2], base[2], frac[2]);
    for (int c = 0; c < NUM_CORNERS; c++) begin
      // bit2 picks the x side, bit0 the z side
      ofs = 3'(c);
      for (int a = 0; a < NUM_AXES; a++) begin
        wt[a] = ofs[2-a] ? frac[a] : ONE - frac[a];
      end
      gx = (wt[1] * wt[2]) >> FRAC;
      gy = (wt[0] * wt[2]) >> FRAC;
      gz = (wt[0] * wt[1]) >> FRAC;
      word.corner = CORNER_W'(c);
      word.node_x = clamp_node(base[0] + longint'(ofs[2]));
      word.node_y = clamp_node(base[1] + longint'(ofs[1]));
      word.node_z = clamp_node(base[2] + longint'(ofs[0]));
      word.weight = WEIGHT_W'((((wt[0] * wt[1]) >> FRAC) * wt[2]) >> FRAC);
      word.grad_x = ofs[2] ? GRAD_W'(gx) : GRAD_W'(64'd0 - gx);
      word.grad_y = ofs[1] ? GRAD_W'(gy) : GRAD_W'(64'd0 - gy);
      word.grad_z = ofs[0] ? GRAD_W'(gz) : GRAD_W'(64'd0 - gz);
      word.last   = (c == NUM_CORNERS - 1);
      expected_corners.push_back(word);
    end
  endfunction

  task automatic check_field(input string fname, input logic signed [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", fname, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        origin[a]      = '0;
        inv_spacing[a] = INV_RESET;
      end
      expected_corners.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_corners.size() == 0) begin
          $error("corner word %0d with nothing expected", corner_i);
          fail_cnt++;
        end else begin
          want = expected_corners.pop_front();
          check_field("corner", want.corner, corner_i);
          check_field("node_x", want.node_x, node_x_i);
          check_field("node_y", want.node_y, node_y_i);
          check_field("node_z", want.node_z, node_z_i);
          check_field("weight", want.weight, weight_i);
          check_field("grad_x", want.grad_x, grad_x_i);
          check_field("grad_y", want.grad_y, grad_y_i);
          check_field("grad_z", want.grad_z, grad_z_i);
          check_field("last", want.last, last_i);
        end
      end
      // a position taken on this edge still sees the old grid
      if (start_i && !busy_i) predict_corners(pos_x_i, pos_y_i, pos_z_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ORIGIN_X: origin[0]      = cfg_wdata_i;
          REG_ORIGIN_Y: origin[1]      = cfg_wdata_i;
          REG_ORIGIN_Z: origin[2]      = cfg_wdata_i;
          REG_INV_X:    inv_spacing[0] = cfg_wdata_i;
          REG_INV_Y:    inv_spacing[1] = cfg_wdata_i;
          REG_INV_Z:    inv_spacing[2] = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pending = expected_corners.size();
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tlwg_pkg::*;

  // spare indexes of the write port, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic [DATA_W-1:0] Q_ONE   = 32'h0001_0000;
  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] POS_MIN = 32'h8000_0000;

  localparam int GAP_MAX     = 19;
  localparam int TAIL_CYCLES = 14;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 33;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // command side
  logic                     start = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] pos_x_i = '0;
  logic signed [DATA_W-1:0] pos_y_i = '0;
  logic signed [DATA_W-1:0] pos_z_i = '0;

  // register write port
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;

  // result side
  logic                     result_valid_o;
  logic [CORNER_W-1:0]      corner_o;
  logic signed [NODE_W-1:0] node_x_o;
  logic signed [NODE_W-1:0] node_y_o;
  logic signed [NODE_W-1:0] node_z_o;
  logic [WEIGHT_W-1:0]      weight_o;
  logic signed [GRAD_W-1:0] grad_x_o;
  logic signed [GRAD_W-1:0] grad_y_o;
  logic signed [GRAD_W-1:0] grad_z_o;
  logic                     last_o;

  int fail_cnt;
  int pending;

  // stimulus side copy of the grid anchor, so positions land near it
  logic [DATA_W-1:0] grid_origin [NUM_AXES] = '{default: '0};
  bit                no_idle = 1'b0;

  always #5 clk_i = ~clk_i;

  trilinear_weights_and_gradients u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .corner_o      (corner_o),
    .node_x_o      (node_x_o),
    .node_y_o      (node_y_o),
    .node_z_o      (node_z_o),
    .weight_o      (weight_o),
    .grad_x_o      (grad_x_o),
    .grad_y_o      (grad_y_o),
    .grad_z_o      (grad_z_o),
    .last_o        (last_o)
  );

  // watches both sides, predicts the eight corner words and compares
  tlwg_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_i(result_valid_o),
    .corner_i      (corner_o),
    .node_x_i      (node_x_o),
    .node_y_i      (node_y_o),
    .node_z_i      (node_z_o),
    .weight_i      (weight_o),
    .grad_x_i      (grad_x_o),
    .grad_y_i      (grad_y_o),
    .grad_z_i      (grad_z_o),
    .last_i        (last_o),
    .fail_cnt_o    (fail_cnt),
    .pending_o     (pending)
  );

  // one register write, enable dropped on the next edge
  task automatic write_grid_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // only called with the block idle and start low
  task automatic set_grid(input logic [DATA_W-1:0] ox, oy, oz, ix, iy, iz);
    write_grid_reg(REG_ORIGIN_X, ox);
    write_grid_reg(REG_ORIGIN_Y, oy);
    write_grid_reg(REG_ORIGIN_Z, oz);
    write_grid_reg(REG_INV_X, ix);
    write_grid_reg(REG_INV_Y, iy);
    write_grid_reg(REG_INV_Z, iz);
    grid_origin = '{ox, oy, oz};
  endtask

  // hand one position over; returns on the edge that takes it, start still high
  task automatic push_particle(input logic [DATA_W-1:0] px, py, pz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and let every expected word come out
  task automatic drain_corners();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return POS_MAX;
      1:       return POS_MIN;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // mostly within 2^23 position units of the anchor, sometimes anywhere
  function automatic logic [DATA_W-1:0] rand_coord(input int axis);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return pick_extreme();
      default: return grid_origin[axis] + 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_inv();
    case ($urandom_range(0, 5))
      0:       return Q_ONE;
      1:       return $urandom;
      2: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return 32'd1;
          default: return '1;
        endcase
      end
      default: return 32'($urandom_range(32'h0000_2000, 32'h0008_0000));
    endcase
  endfunction

  task automatic randomize_grid();
    logic [DATA_W-1:0] org [NUM_AXES];
    for (int a = 0; a < NUM_AXES; a++) begin
      org[a] = $urandom_range(0, 1) ? $urandom
                                    : 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    end
    set_grid(org[0], org[1], org[2], rand_inv(), rand_inv(), rand_inv());
    if ($urandom_range(0, 2) == 0) begin
      write_grid_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset grid: unit spacing, anchor at zero
    push_particle('0, '0, '0);
    push_particle(POS_MAX, POS_MAX, POS_MAX);
    push_particle(POS_MIN, POS_MIN, POS_MIN);
    push_particle('1, '1, '1);
    push_particle(32'h0000_8000, 32'h0001_4000, 32'hFFFD_4000);
    push_particle(32'h5555_5555, 32'hAAAA_AAAA, 32'h0064_8000);
    push_particle(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001);
    drain_corners();

    // anchor at the top, finest spacing: differences of almost 2^32, index clamps
    set_grid(POS_MAX, POS_MAX, POS_MAX, '1, '1, '1);
    no_idle = 1'b1;
    push_particle(POS_MIN, POS_MIN, POS_MIN);
    push_particle(POS_MAX, '0, 32'h7FFF_0001);
    push_particle('0, POS_MIN, '1);
    drain_corners();

    // anchor at the bottom, widest spacing; spare indexes must be ignored
    set_grid(POS_MIN, POS_MIN, POS_MIN, 32'd1, 32'd1, 32'd1);
    write_grid_reg(REG_SPARE_A, '1);
    write_grid_reg(REG_SPARE_B, 32'h1234_5678);
    no_idle = 1'b0;
    push_particle(POS_MAX, POS_MAX, POS_MAX);
    push_particle(POS_MIN, 32'h1234_5678, '0);
    push_particle('0, '1, 32'h8000_0001);
    drain_corners();

    // zero inverse spacing on x, 1.5 on y so negative offsets round down, tiny on z
    set_grid(32'h0000_0003, 32'h0000_0002, '0, '0, 32'h0001_8000, 32'd1);
    push_particle('1, '1, '1);
    push_particle(32'hFFFF_FFFD, 32'hFFFF_FFFD, 32'hFFFF_0000);
    push_particle(POS_MAX, 32'h0002_0001, POS_MIN);
    drain_corners();

    // random grids, one phase in three back to back; at times the sender waits for all
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      randomize_grid();
      no_idle = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 29) == 0) drain_corners();
        push_particle(rand_coord(0), rand_coord(1), rand_coord(2));
      end
      drain_corners();
    end

    if (fail_cnt == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
